[src/oal_pkg.sv]
// Package for the ordered array list: command codes, widths and the
// control bundle that the top level broadcasts to every cell.
// No dependencies.
package oal_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_LOCATE = 2'd3
  } cmd_e;

  localparam int DefaultCapacity = 16;
  localparam int PosW            = 5;
  localparam int WordW           = 32;

  typedef struct packed {
    logic              take;
    logic              ins;
    logic              del;
    logic              get;
    logic              loc;
    logic [WordW-1:0]  value;
  } cell_ctrl_t;

endpackage

[src/oal_in_if.sv]
// Input channel of the ordered array list: valid/ready plus one command.
// Depends on oal_pkg.
interface oal_in_if;
  logic                              valid;
  logic                              ready;
  oal_pkg::cmd_e                     command;
  logic [oal_pkg::PosW-1:0]          position;
  logic signed [oal_pkg::WordW-1:0]  value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

[src/oal_out_if.sv]
// Result channel of the ordered array list: valid/ready plus one result.
// Depends on oal_pkg.
interface oal_out_if;
  logic                              valid;
  logic                              ready;
  logic                              success;
  logic signed [oal_pkg::WordW-1:0]  read_value;
  logic [oal_pkg::PosW-1:0]          found_position;
  logic [oal_pkg::PosW-1:0]          count;

  modport source (output valid, output success, output read_value, output found_position,
                  output count, input ready);
  modport sink   (input valid, input success, input read_value, input found_position,
                  input count, output ready);
endinterface

[src/ordered_array_list.sv]
// Top level of the ordered array list: a row of cells, the fill count and
// the result register. Depends on oal_pkg, oal_in_if, oal_out_if, oal_cell.
//
// A bounded list of up to CAPACITY signed 32-bit words in positions
// 1..count. Commands insert, delete, get and locate each give one result
// with a success flag and the count after the command. In the cycle of the
// transfer all cells shift and compare in parallel and register their hit
// flags; once the result register is free, the flags are reduced into it.
// No new command is taken until the last one is in the result register, but
// the next command is taken while a finished result still waits. No
// clearing pass after reset is needed.
module ordered_array_list #(
  parameter int CAPACITY = oal_pkg::DefaultCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  oal_in_if.sink    in_i,
  oal_out_if.source out_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > oal_pkg::PosW) ? CntW : oal_pkg::PosW;
  localparam int WW   = oal_pkg::WordW;

  logic [CntW-1:0]           count_q, count_d;
  logic                      busy_q;
  logic                      ok_q, loc_q;
  logic                      out_valid_q;
  logic                      out_success_q;
  logic [WW-1:0]             out_read_q;
  logic [oal_pkg::PosW-1:0]  out_found_q, out_count_q;

  logic                      in_xfer, load;
  logic [CmpW-1:0]           pos_w, pos_idx, count_w;
  logic                      pos_nz, ins_ok, rd_ok, op_ok;
  oal_pkg::cell_ctrl_t       ctrl;

  logic [WW-1:0]             data   [CAPACITY];
  logic [WW-1:0]             cap    [CAPACITY];
  logic [CAPACITY-1:0]       sel, match;
  logic [WW-1:0]             read_val;
  logic [oal_pkg::PosW-1:0]  found;

  assign in_i.ready = !busy_q;
  assign in_xfer    = in_i.valid && !busy_q;

  assign pos_w   = CmpW'(in_i.position);
  assign pos_idx = pos_w - CmpW'(1);
  assign count_w = CmpW'(count_q);
  assign pos_nz  = (in_i.position != '0);
  assign ins_ok  = pos_nz && (pos_idx <= count_w) && (count_w < CmpW'(CAPACITY));
  assign rd_ok   = pos_nz && (pos_idx < count_w);

  always_comb begin
    ctrl.take  = in_xfer;
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.get   = 1'b0;
    ctrl.loc   = 1'b0;
    ctrl.value = in_i.value;
    op_ok      = 1'b0;
    count_d    = count_q;
    if (in_xfer) begin
      case (in_i.command)
        oal_pkg::CMD_INSERT: begin
          ctrl.ins = ins_ok;
          op_ok    = ins_ok;
          if (ins_ok) count_d = count_q + CntW'(1);
        end
        oal_pkg::CMD_DELETE: begin
          ctrl.del = rd_ok;
          op_ok    = rd_ok;
          if (rd_ok) count_d = count_q - CntW'(1);
        end
        oal_pkg::CMD_GET: begin
          ctrl.get = rd_ok;
          op_ok    = rd_ok;
        end
        oal_pkg::CMD_LOCATE: begin
          ctrl.loc = 1'b1;
        end
        default: begin
          op_ok = 1'b0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = in_i.value;
    end else begin : g_mid
      assign left = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = data[i];
    end else begin : g_inner
      assign right = data[i+1];
    end
    oal_cell #(
      .CmpW(CmpW),
      .Idx (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .pos_idx_i(pos_idx),
      .count_i  (count_w),
      .left_i   (left),
      .right_i  (right),
      .data_o   (data[i]),
      .sel_o    (sel[i]),
      .match_o  (match[i]),
      .cap_o    (cap[i])
    );
  end

  always_comb begin
    read_val = '0;
    found    = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (sel[i]) read_val = read_val | cap[i];
      if (match[i]) found = oal_pkg::PosW'(i + 1);
    end
  end

  assign load = busy_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      ok_q        <= 1'b0;
      loc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        busy_q <= 1'b1;
        ok_q   <= op_ok;
        loc_q  <= ctrl.loc;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_success_q <= ok_q || (loc_q && (match != '0));
      out_read_q    <= read_val;
      out_found_q   <= found;
      out_count_q   <= oal_pkg::PosW'(count_q);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.success        = out_success_q;
  assign out_o.read_value     = out_read_q;
  assign out_o.found_position = out_found_q;
  assign out_o.count          = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel))
    else $error("more than one cell selected for read");

  a_xfer_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_q)
    else $error("command transfer did not start evaluation");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(count_q))
    else $error("fill count changed without a transfer");

endmodule

[src/oal_cell.sv]
// One list cell: holds one entry, shifts with its neighbors on insert and
// delete, and flags a position hit or a value match. Depends on oal_pkg.
module oal_cell #(
  parameter int CmpW = 5,
  parameter int Idx  = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  oal_pkg::cell_ctrl_t       ctrl_i,
  input  logic [CmpW-1:0]           pos_idx_i,
  input  logic [CmpW-1:0]           count_i,
  input  logic [oal_pkg::WordW-1:0] left_i,
  input  logic [oal_pkg::WordW-1:0] right_i,
  output logic [oal_pkg::WordW-1:0] data_o,
  output logic                      sel_o,
  output logic                      match_o,
  output logic [oal_pkg::WordW-1:0] cap_o
);

  logic [oal_pkg::WordW-1:0] data_q, data_d;
  logic [oal_pkg::WordW-1:0] cap_q;
  logic                      sel_q, match_q;
  logic                      at_pos, above_pos, live;

  assign at_pos    = (pos_idx_i == CmpW'(Idx));
  assign above_pos = (CmpW'(Idx) > pos_idx_i);
  assign live      = (CmpW'(Idx) < count_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (at_pos) begin
        data_d = ctrl_i.value;
      end else if (above_pos) begin
        data_d = left_i;
      end
    end else if (ctrl_i.del && (at_pos || above_pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctrl_i.take) begin
      cap_q <= data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      match_q <= 1'b0;
    end else if (ctrl_i.take) begin
      sel_q   <= (ctrl_i.del || ctrl_i.get) && at_pos;
      match_q <= ctrl_i.loc && live && (data_q == ctrl_i.value);
    end
  end

  assign data_o  = data_q;
  assign sel_o   = sel_q;
  assign match_o = match_q;
  assign cap_o   = cap_q;

endmodule

[tb/testbench.sv]
// Testbench for ordered_array_list: drives commands over the input channel,
// predicts each result with a scoreboard that keeps its own copy of the list,
// and checks every result transfer. Depends on every file in src.
module testbench;

  localparam int Capacity = oal_pkg::DefaultCapacity;
  localparam int WordW = oal_pkg::WordW;
  localparam int PosW = oal_pkg::PosW;
  localparam int HoldCycles = 400;
  localparam int HoldAfter = 1100;

  typedef struct packed {
    logic             success;
    logic [WordW-1:0] read_value;
    logic [PosW-1:0]  found_position;
    logic [PosW-1:0]  count;
  } list_result_t;

  class list_scoreboard;
    logic [WordW-1:0] words[Capacity];
    int unsigned      fill;
    int unsigned      taken;
    int unsigned      failures;
    list_result_t     due_q[$];

    function new();
      fill = 0;
      taken = 0;
      failures = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void note_command(oal_pkg::cmd_e cmd, logic [PosW-1:0] pos,
                               logic [WordW-1:0] val);
      list_result_t r;
      int unsigned  p;
      p = 32'(pos);
      r = '0;
      taken++;
      case (cmd)
        oal_pkg::CMD_INSERT: begin
          if (p >= 1 && p <= fill + 1 && fill < Capacity) begin
            for (int j = fill; j >= int'(p); j--) words[j] = words[j-1];
            words[p-1] = val;
            fill++;
            r.success = 1'b1;
          end
        end
        oal_pkg::CMD_DELETE: begin
          if (p >= 1 && p <= fill) begin
            r.read_value = words[p-1];
            for (int j = p; j < int'(fill); j++) words[j-1] = words[j];
            fill--;
            r.success = 1'b1;
          end
        end
        oal_pkg::CMD_GET: begin
          if (p >= 1 && p <= fill) begin
            r.read_value = words[p-1];
            r.success = 1'b1;
          end
        end
        default: begin
          for (int j = 0; j < int'(fill); j++) begin
            if (words[j] == val) begin
              r.found_position = PosW'(j + 1);
              r.success = 1'b1;
              break;
            end
          end
        end
      endcase
      r.count = PosW'(fill);
      due_q.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (due_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: success=%0b read=%h found=%0d count=%0d",
                   got.success, got.read_value, got.found_position, got.count);
        return;
      end
      want = due_q.pop_front();
      if (got.success !== want.success || got.read_value !== want.read_value ||
          got.found_position !== want.found_position || got.count !== want.count) begin
        failures++;
        if (failures <= 10)
          $display({"result mismatch: expected s=%0b rd=%h fp=%0d n=%0d,",
                    " got s=%0b rd=%h fp=%0d n=%0d"},
                   want.success, want.read_value, want.found_position, want.count,
                   got.success, got.read_value, got.found_position, got.count);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm = 1'b0;
  bit   hold_done = 1'b0;

  list_scoreboard sb = new();

  oal_in_if  in_ch();
  oal_out_if out_ch();

  ordered_array_list #(.CAPACITY(Capacity)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && sb.taken >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 32);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.success, out_ch.read_value, out_ch.found_position,
                       out_ch.count});
  end

  task automatic send_item(oal_pkg::cmd_e cmd, logic [PosW-1:0] pos, logic [WordW-1:0] val);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_command(cmd, pos, val);
  endtask

  task automatic send_random(int ins_pct);
    oal_pkg::cmd_e    cmd;
    logic [PosW-1:0]  pos;
    logic [WordW-1:0] val;
    int unsigned      n;
    n = sb.fill;
    if ($urandom_range(0, 99) < ins_pct) begin
      cmd = oal_pkg::CMD_INSERT;
    end else begin
      case ($urandom_range(0, 2))
        0: cmd = oal_pkg::CMD_DELETE;
        1: cmd = oal_pkg::CMD_GET;
        default: cmd = oal_pkg::CMD_LOCATE;
      endcase
    end
    if ($urandom_range(0, 99) < 15)
      pos = PosW'($urandom_range(0, 31));
    else if (cmd == oal_pkg::CMD_INSERT)
      pos = PosW'($urandom_range(1, n + 1));
    else
      pos = (n == 0) ? PosW'(1) : PosW'($urandom_range(1, n));
    case ($urandom_range(0, 3))
      0: val = WordW'(int'($urandom_range(0, 7)) - 4);
      1: val = (n > 0) ? sb.words[$urandom_range(0, n - 1)] : $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2: val = 32'h0000_0000;
          default: val = 32'hffff_ffff;
        endcase
      end
      default: val = $urandom;
    endcase
    send_item(cmd, pos, val);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.command  = oal_pkg::CMD_INSERT;
    in_ch.position = '0;
    in_ch.value    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(oal_pkg::CMD_GET,    5'd1,  32'h0000_0000);
    send_item(oal_pkg::CMD_DELETE, 5'd1,  32'h0000_0000);
    send_item(oal_pkg::CMD_LOCATE, 5'd0,  32'h0000_0000);
    send_item(oal_pkg::CMD_INSERT, 5'd0,  32'h0000_0005);
    send_item(oal_pkg::CMD_INSERT, 5'd2,  32'h0000_0005);
    send_item(oal_pkg::CMD_INSERT, 5'd1,  32'h8000_0000);
    send_item(oal_pkg::CMD_INSERT, 5'd2,  32'h7fff_ffff);
    send_item(oal_pkg::CMD_INSERT, 5'd1,  32'hffff_ffff);
    send_item(oal_pkg::CMD_INSERT, 5'd2,  32'h0000_0000);
    send_item(oal_pkg::CMD_INSERT, 5'd31, 32'h1234_5678);
    send_item(oal_pkg::CMD_GET,    5'd0,  32'h0000_0000);
    send_item(oal_pkg::CMD_GET,    5'd4,  32'h0000_0000);
    send_item(oal_pkg::CMD_GET,    5'd5,  32'h0000_0000);
    send_item(oal_pkg::CMD_LOCATE, 5'd0,  32'h7fff_ffff);
    send_item(oal_pkg::CMD_INSERT, 5'd5,  32'h7fff_ffff);
    send_item(oal_pkg::CMD_LOCATE, 5'd31, 32'h7fff_ffff);
    send_item(oal_pkg::CMD_LOCATE, 5'd0,  32'h0000_3039);
    send_item(oal_pkg::CMD_DELETE, 5'd2,  32'h0000_0000);
    send_item(oal_pkg::CMD_DELETE, 5'd0,  32'h0000_0000);
    send_item(oal_pkg::CMD_DELETE, 5'd31, 32'h0000_0000);
    send_item(oal_pkg::CMD_DELETE, 5'd4,  32'h0000_0000);
    send_item(oal_pkg::CMD_GET,    5'd2,  32'h0000_0000);

    repeat (300) send_random(75);
    drain();
    repeat (300) send_random(25);
    calm = 1'b1;
    repeat (300) send_random(50);
    calm = 1'b0;
    repeat (600) send_random(50);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
